// ----- hdl/jd2cal_pkg.sv -----
// constants, payload layout and month table for the julian day to calendar date converter
// standalone package, no dependencies
package jd2cal_pkg;

	localparam int TDATA_IN_W  = 56;
	localparam int TDATA_OUT_W = 56;

	// day number fixups
	localparam logic [26:0]        MS_PER_DAY = 27'd86400000;
	localparam logic signed [23:0] MJD_TO_JDN = 24'sd2400001;
	localparam logic signed [23:0] GREG_START = 24'sd2299161;

	// alpha = floor((4z - ALPHA_OFS) / ALPHA_DIV), same as the 36524.25 century form
	localparam logic signed [26:0] ALPHA_OFS   = 27'sd7468865;
	localparam logic [24:0]        ALPHA_DIV   = 25'd146097;
	localparam logic [7:0]         ALPHA_RECIP = 8'd229;      // floor(2^25 / 146097)

	// c = floor((20b - 2442) / 7305); numerator biased by C_BIAS * 7305 to stay positive
	localparam logic signed [29:0] C_OFS   = 30'sd35857803;
	localparam logic [27:0]        C_DIV   = 28'd7305;
	localparam logic [15:0]        C_RECIP = 16'd36746;      // floor(2^28 / 7305)
	localparam logic [15:0]        C_BIAS  = 16'd4909;

	localparam logic signed [26:0] DAYS_PER_4Y = 27'sd1461;
	localparam int                 E_NUM       = 306001;
	localparam logic [22:0]        E_SCALE     = 23'd10000;

	// time of day
	localparam logic [26:0] MS_DIV    = 27'd1000;
	localparam logic [17:0] MS_RECIP  = 18'd134217;          // floor(2^27 / 1000)
	localparam logic [11:0] MIN_RECIP = 12'd2184;            // floor(2^17 / 60)
	localparam logic [5:0]  HR_RECIP  = 6'd34;               // floor(2^11 / 60)

	// result word, first member in the top bits so year lands at bit 0
	typedef struct packed {
		logic [9:0]  millisecond;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [14:0] year;
	} date_time_t;

	// floor(30.6001 * e) for the month index
	function automatic logic [8:0] month_offset(input logic [3:0] e);
		logic [8:0] r;
		unique case (e)
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd183;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd244;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd336;
			4'd12:   r = 9'd367;
			4'd13:   r = 9'd397;
			4'd14:   r = 9'd428;
			4'd15:   r = 9'd459;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/julian_day_to_calendar_date.sv -----
// modified julian date to calendar date and time of day, ten stage pipeline
// depends on jd2cal_pkg for constants, the result layout and the month table
// throughput: one word per cycle if unstalled; each stage holds one item and moves on when the next frees
// constant divisions are reciprocal multiplies with one correction step spread over stages
// reset clears the stage valid bits only; the data path is not reset
module julian_day_to_calendar_date (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// day_number[22:0] (signed), ms_of_day[49:23], zero fill
	input  logic [jd2cal_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// year[14:0] (signed), month[18:15], day_of_month[23:19], hour[28:24],
	// minute[34:29], second[40:35], millisecond[50:41], zero fill
	output logic [jd2cal_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
	import jd2cal_pkg::*;

	localparam int NUM_STG = 10;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] rdy;

	function automatic logic [24:0] na_of(input logic signed [23:0] z);
		logic signed [26:0] t;
		t = z;
		t = (t <<< 2) - ALPHA_OFS;
		return t[24:0];
	endfunction

	function automatic logic [27:0] nc_of(input logic signed [23:0] b);
		logic signed [29:0] t;
		t = b;
		t = t * 30'sd20 + C_OFS;
		return t[27:0];
	endfunction

	// stage registers
	logic signed [23:0] z_s1, z_s2, z_s3;
	logic [26:0]        ms_s1, ms_s2;
	logic               greg_s2, greg_s3;
	logic [32:0]        alpha_p_s2;
	logic [44:0]        ms_p_s2;
	logic [7:0]         aq0_s3;
	logic               afix_s3;
	logic [16:0]        sq0_s3;
	logic [10:0]        mr_s3;
	logic signed [23:0] b_s4, b_s5, b_s6, b_s7;
	logic [16:0]        sec_s4, sec_s5;
	logic [9:0]         milli_s4, milli_s5, milli_s6, milli_s7, milli_s8, milli_s9;
	logic [43:0]        c_p_s5;
	logic [28:0]        min_p_s5;
	logic [14:0]        cq0_s6;
	logic               cfix_s6;
	logic [10:0]        mq0_s6;
	logic [6:0]         sr_s6;
	logic signed [15:0] c_s7, c_s8, c_s9;
	logic [10:0]        min_s7, min_s8;
	logic [5:0]         second_s7, second_s8, second_s9;
	logic [8:0]         x_s8, x_s9;
	logic [16:0]        hr_p_s8;
	logic [3:0]         e_s9;
	logic [4:0]         hour_s9;
	logic [5:0]         minute_s9;
	date_time_t         out_s10;

	// stage logic
	logic signed [22:0] dn_in;
	logic signed [23:0] dn_x;
	logic [26:0]        ms_in;
	logic               wrap;
	logic signed [23:0] z_in;
	logic [7:0]         aq0;
	logic [24:0]        ar;
	logic [16:0]        sq0;
	logic [26:0]        mr;
	logic [7:0]         alpha;
	logic signed [23:0] a_w, b_w;
	logic               mfix;
	logic [16:0]        sec_w;
	logic [9:0]         milli_w;
	logic [14:0]        cq0;
	logic [27:0]        cr;
	logic [10:0]        mq0;
	logic [16:0]        sr;
	logic signed [15:0] c_w;
	logic               sfix;
	logic [10:0]        min_w;
	logic [5:0]         second_w;
	logic signed [26:0] cx, dm, d_w, bx, xd;
	logic [22:0]        ex;
	logic [3:0]         e_w;
	logic [4:0]         hq0;
	logic [10:0]        hr;
	logic               hfix;
	logic [4:0]         hour_w;
	logic [5:0]         minute_w;
	logic [3:0]         month_w;
	logic signed [15:0] year_w;
	logic [8:0]         day_w;

	// a stage takes a new item when it is empty or its own item moves on
	always_comb begin
		rdy[NUM_STG-1] = !vld_q[NUM_STG-1] || m_axis_tready;
		for (int k = NUM_STG - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign s_axis_tready = rdy[0];
	assign m_axis_tvalid = vld_q[NUM_STG-1];
	assign m_axis_tdata  = {{(TDATA_OUT_W - $bits(date_time_t)){1'b0}}, out_s10};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// s1: full day rollover and julian day number
	always_comb begin
		dn_in = s_axis_tdata[22:0];
		ms_in = s_axis_tdata[49:23];
		dn_x  = dn_in;
		wrap  = ms_in >= MS_PER_DAY;
		z_in  = dn_x + MJD_TO_JDN + 24'(wrap);
	end

	// s3: first quotient guesses and remainders
	always_comb begin
		aq0  = alpha_p_s2[32:25];
		ar   = na_of(z_s2) - 25'(aq0) * ALPHA_DIV;
		sq0  = ms_p_s2[43:27];
		mr   = ms_s2 - 27'(sq0) * MS_DIV;
	end

	// s4: corrected alpha, gregorian fixup, b, corrected seconds and milliseconds
	always_comb begin
		alpha   = aq0_s3 + 8'(afix_s3);
		a_w     = greg_s3 ? z_s3 + 24'sd1 + 24'(alpha) - 24'(alpha[7:2]) : z_s3;
		b_w     = a_w + 24'sd1524;
		mfix    = mr_s3 >= 11'd1000;
		sec_w   = sq0_s3 + 17'(mfix);
		milli_w = mfix ? 10'(mr_s3 - 11'd1000) : mr_s3[9:0];
	end

	// s6: year count guess and remainder, minute guess and remainder
	always_comb begin
		cq0 = c_p_s5[42:28];
		cr  = nc_of(b_s5) - 28'(cq0) * C_DIV;
		mq0 = min_p_s5[27:17];
		sr  = sec_s5 - 17'(mq0) * 17'd60;
	end

	// s7: corrected year count, minutes of day
	always_comb begin
		c_w      = 16'(cq0_s6) + 16'(cfix_s6) - C_BIAS;
		sfix     = sr_s6 >= 7'd60;
		min_w    = mq0_s6 + 11'(sfix);
		second_w = sfix ? 6'(sr_s6 - 7'd60) : sr_s6[5:0];
	end

	// s8: days left in the year after the march-based year start
	always_comb begin
		cx = c_s7;
		dm = cx * DAYS_PER_4Y;
		d_w = dm >>> 2;
		bx = b_s7;
		xd = bx - d_w;
	end

	// s9: month index by threshold count, hour split
	always_comb begin
		ex  = 23'(x_s8) * E_SCALE;
		e_w = 4'd4;
		for (int k = 5; k <= 15; k++) begin
			if (ex >= 23'(E_NUM * k)) begin
				e_w = e_w + 4'd1;
			end
		end
		hq0      = hr_p_s8[15:11];
		hr       = min_s8 - 11'(hq0) * 11'd60;
		hfix     = hr >= 11'd60;
		hour_w   = hq0 + 5'(hfix);
		minute_w = hfix ? 6'(hr - 11'd60) : hr[5:0];
	end

	// s10: month, year and day of month
	always_comb begin
		month_w = (e_s9 < 4'd14) ? e_s9 - 4'd1 : e_s9 - 4'd13;
		year_w  = (month_w > 4'd2) ? c_s9 - 16'sd4716 : c_s9 - 16'sd4715;
		day_w   = x_s9 - month_offset(e_s9);
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			z_s1  <= z_in;
			ms_s1 <= wrap ? ms_in - MS_PER_DAY : ms_in;
		end
		if (rdy[1]) begin
			z_s2       <= z_s1;
			ms_s2      <= ms_s1;
			greg_s2    <= z_s1 >= GREG_START;
			alpha_p_s2 <= 33'(na_of(z_s1)) * 33'(ALPHA_RECIP);
			ms_p_s2    <= 45'(ms_s1) * 45'(MS_RECIP);
		end
		if (rdy[2]) begin
			z_s3    <= z_s2;
			greg_s3 <= greg_s2;
			aq0_s3  <= aq0;
			afix_s3 <= ar >= ALPHA_DIV;
			sq0_s3  <= sq0;
			mr_s3   <= mr[10:0];
		end
		if (rdy[3]) begin
			b_s4     <= b_w;
			sec_s4   <= sec_w;
			milli_s4 <= milli_w;
		end
		if (rdy[4]) begin
			b_s5     <= b_s4;
			sec_s5   <= sec_s4;
			milli_s5 <= milli_s4;
			c_p_s5   <= 44'(nc_of(b_s4)) * 44'(C_RECIP);
			min_p_s5 <= 29'(sec_s4) * 29'(MIN_RECIP);
		end
		if (rdy[5]) begin
			b_s6     <= b_s5;
			milli_s6 <= milli_s5;
			cq0_s6   <= cq0;
			cfix_s6  <= cr >= C_DIV;
			mq0_s6   <= mq0;
			sr_s6    <= sr[6:0];
		end
		if (rdy[6]) begin
			b_s7      <= b_s6;
			milli_s7  <= milli_s6;
			c_s7      <= c_w;
			min_s7    <= min_w;
			second_s7 <= second_w;
		end
		if (rdy[7]) begin
			c_s8      <= c_s7;
			x_s8      <= xd[8:0];
			min_s8    <= min_s7;
			second_s8 <= second_s7;
			milli_s8  <= milli_s7;
			hr_p_s8   <= 17'(min_s7) * 17'(HR_RECIP);
		end
		if (rdy[8]) begin
			c_s9      <= c_s8;
			x_s9      <= x_s8;
			e_s9      <= e_w;
			hour_s9   <= hour_w;
			minute_s9 <= minute_w;
			second_s9 <= second_s8;
			milli_s9  <= milli_s8;
		end
		if (rdy[9]) begin
			out_s10.year         <= year_w[14:0];
			out_s10.month        <= month_w;
			out_s10.day_of_month <= day_w[4:0];
			out_s10.hour         <= hour_s9;
			out_s10.minute       <= minute_s9;
			out_s10.second       <= second_s9;
			out_s10.millisecond  <= milli_s9;
		end
	end

	// days into the march-based year always land in one year's span
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[7] |-> (x_s8 >= 9'd123 && x_s8 <= 9'd488))
		else $error("day offset out of range after year split");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_s10.month >= 4'd1 && out_s10.month <= 4'd12 &&
			out_s10.day_of_month != 5'd0))
		else $error("calendar date out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_s10.hour <= 5'd23 && out_s10.minute <= 6'd59 &&
			out_s10.second <= 6'd59 && out_s10.millisecond <= 10'd999))
		else $error("time of day out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !m_axis_tready) |-> !s_axis_tready)
		else $error("word taken while every stage is full and stalled");

endmodule
